@@ rtl/urhr_pkg.sv @@
// ----------------------------------------------------------------------------
// urhr_pkg
// Shared constants, types and the one's-complement update helper for the
// UDP relay header rewrite block.
// ----------------------------------------------------------------------------
package urhr_pkg;

    // Rule store geometry
    localparam int RULE_SLOTS = 64;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int SCNT_W     = SLOT_W + 1;

    // Header qualification
    localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
    localparam logic [15:0] ETHTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // Checksum specials
    localparam logic [15:0] CK_NONE     = 16'h0000;
    localparam logic [15:0] CK_ALL_ONES = 16'hFFFF;

    // Result kinds
    typedef logic [1:0] t_action;
    localparam t_action ACT_PASS   = 2'd0;
    localparam t_action ACT_XMIT   = 2'd1;
    localparam t_action ACT_STORED = 2'd2;
    localparam t_action ACT_FULL   = 2'd3;

    // Request kinds
    localparam logic FUNC_RULE   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    // Checksum word select
    typedef logic [1:0] t_ck_sel;
    localparam t_ck_sel CK_SEL_IP_HI = 2'd0;
    localparam t_ck_sel CK_SEL_IP_LO = 2'd1;
    localparam t_ck_sel CK_SEL_PORT  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] frame_len;
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_ip;
        logic [15:0] udp_sport;
        logic [31:0] dst_ip;
        logic [15:0] udp_dport;
        logic [15:0] ip_checksum;
        logic [15:0] udp_checksum;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
    } t_req;

    typedef struct packed {
        t_action     action;
        logic [47:0] out_dest_mac;
        logic [47:0] out_source_mac;
        logic [31:0] out_dst_ip;
        logic [15:0] out_udp_dport;
        logic [15:0] out_ip_checksum;
        logic [15:0] out_udp_checksum;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    scan_clear;
        logic    scan_step;
        logic    store;
        logic    ck_step;
        t_ck_sel ck_sel;
        logic    load_out;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic func;
        logic qualify;
        logic scan_done;
        logic hit;
        logic out_free;
    } t_sts;

    // RFC 1624 word replacement: ~(~hc + ~old + new) with end-around carry
    function automatic logic [15:0] csum_replace(input logic [15:0] hc,
                                                 input logic [15:0] old_w,
                                                 input logic [15:0] new_w);
        logic [17:0] sum;
        logic [16:0] fold1;
        logic [15:0] fold2;
        sum   = {2'b00, ~hc} + {2'b00, ~old_w} + {2'b00, new_w};
        fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        return ~fold2;
    endfunction

endpackage

@@ rtl/urhr_ctrl.sv @@
// ----------------------------------------------------------------------------
// urhr_ctrl
// Sequencer: takes a request, runs the rule scan (not for a packet that fails
// to qualify), the store or the checksum steps, and loads the output register.
// ----------------------------------------------------------------------------
module urhr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  urhr_pkg::t_sts i_sts,
    output urhr_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_CK0   = 3'd4;
    localparam logic [2:0] ST_CK1   = 3'd5;
    localparam logic [2:0] ST_CK2   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_tready = (r_state == ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.func == urhr_pkg::FUNC_PACKET && !i_sts.qualify) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.func == urhr_pkg::FUNC_RULE) n_state = ST_STORE;
                    else if (i_sts.hit)                   n_state = ST_CK0;
                    else                                  n_state = ST_OUT;
                end
            end
            ST_STORE: n_state = ST_OUT;
            ST_CK0:   n_state = ST_CK1;
            ST_CK1:   n_state = ST_CK2;
            ST_CK2:   n_state = ST_OUT;
            ST_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.scan_clear = (r_state == ST_CHECK);
        o_cmd.scan_step  = (r_state == ST_SCAN) && !i_sts.scan_done;
        o_cmd.store      = (r_state == ST_STORE);
        o_cmd.ck_step    = (r_state == ST_CK0) || (r_state == ST_CK1) ||
                           (r_state == ST_CK2);
        o_cmd.load_out   = (r_state == ST_OUT) && i_sts.out_free;
        case (r_state)
            ST_CK0:  o_cmd.ck_sel = urhr_pkg::CK_SEL_IP_HI;
            ST_CK1:  o_cmd.ck_sel = urhr_pkg::CK_SEL_IP_LO;
            ST_CK2:  o_cmd.ck_sel = urhr_pkg::CK_SEL_PORT;
            default: o_cmd.ck_sel = urhr_pkg::CK_SEL_IP_HI;
        endcase
    end

endmodule

@@ rtl/urhr_dp.sv @@
// ----------------------------------------------------------------------------
// urhr_dp
// Datapath: request register, rule store with a one-entry-per-cycle scan,
// shared checksum update step and the result register.
// ----------------------------------------------------------------------------
module urhr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  urhr_pkg::t_cmd i_cmd,
    output urhr_pkg::t_sts o_sts,
    input  urhr_pkg::t_req i_req,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output urhr_pkg::t_rsp o_rsp
);

    localparam int SLOT_W = urhr_pkg::SLOT_W;
    localparam int SCNT_W = urhr_pkg::SCNT_W;

    // Captured request
    urhr_pkg::t_req r_req;

    // Rule store: {key, target}, valid bits in flops
    logic [95:0]                       r_mem [urhr_pkg::RULE_SLOTS];
    logic [urhr_pkg::RULE_SLOTS-1:0]   r_valid;

    // Scan pipeline
    logic [SCNT_W-1:0] r_idx;
    logic [95:0]       r_rd_data;
    logic              r_rd_vbit;
    logic              r_rd_live;
    logic [SLOT_W-1:0] r_rd_idx;

    // Scan results
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic [47:0]       r_hit_tgt;
    logic              r_free_found;
    logic [SLOT_W-1:0] r_free_idx;

    // Running checksums
    logic [15:0] r_ip_ck;
    logic [15:0] r_udp_ck;

    // Result register
    logic           r_out_valid;
    urhr_pkg::t_rsp r_rsp;
    urhr_pkg::t_rsp n_rsp;

    logic [47:0]       w_key;
    logic              w_idx_live;
    logic [SLOT_W-1:0] w_slot;
    logic [SLOT_W-1:0] w_wr_slot;
    logic              w_key_match;
    logic [15:0]       w_old_w;
    logic [15:0]       w_new_w;
    logic              w_xmit;
    logic [15:0]       w_udp_final;

    assign w_key      = {r_req.src_ip, r_req.udp_sport};
    assign w_idx_live = (r_idx < SCNT_W'(urhr_pkg::RULE_SLOTS));
    assign w_slot     = r_idx[SLOT_W-1:0];
    assign w_wr_slot  = r_hit ? r_hit_idx : r_free_idx;
    assign w_key_match = (r_rd_data[95:48] == w_key);

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req;
        end
    end

    // Rule store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_hit || r_free_found)) begin
            r_mem[w_wr_slot] <= {w_key, r_req.dst_ip, r_req.udp_dport};
        end
        if (i_cmd.scan_step && w_idx_live) begin
            r_rd_data <= r_mem[w_slot];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.store && (r_hit || r_free_found)) begin
            r_valid[w_wr_slot] <= 1'b1;
        end
    end

    // Scan address, read stage and compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_idx        <= '0;
            r_rd_live    <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_rd_live <= w_idx_live;
                if (w_idx_live) begin
                    r_idx <= r_idx + SCNT_W'(1);
                end
            end else begin
                r_rd_live <= 1'b0;
            end
            if (r_rd_live && r_rd_vbit && w_key_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (r_rd_live && !r_rd_vbit && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // Scan payload (no reset needed)
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_idx_live) begin
            r_rd_vbit <= r_valid[w_slot];
            r_rd_idx  <= w_slot;
        end
        if (r_rd_live && r_rd_vbit && w_key_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
            r_hit_tgt <= r_rd_data[47:0];
        end
        if (r_rd_live && !r_rd_vbit && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
    end

    // Checksum word select
    always_comb begin
        case (i_cmd.ck_sel)
            urhr_pkg::CK_SEL_IP_HI: begin
                w_old_w = r_req.dst_ip[31:16];
                w_new_w = r_hit_tgt[47:32];
            end
            urhr_pkg::CK_SEL_IP_LO: begin
                w_old_w = r_req.dst_ip[15:0];
                w_new_w = r_hit_tgt[31:16];
            end
            urhr_pkg::CK_SEL_PORT: begin
                w_old_w = r_req.udp_dport;
                w_new_w = r_hit_tgt[15:0];
            end
            default: begin
                w_old_w = r_req.udp_dport;
                w_new_w = r_hit_tgt[15:0];
            end
        endcase
    end

    // Incremental checksum update, one word pair per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ip_ck  <= i_req.ip_checksum;
            r_udp_ck <= i_req.udp_checksum;
        end else if (i_cmd.ck_step) begin
            if (i_cmd.ck_sel != urhr_pkg::CK_SEL_PORT) begin
                r_ip_ck <= urhr_pkg::csum_replace(r_ip_ck, w_old_w, w_new_w);
            end
            r_udp_ck <= urhr_pkg::csum_replace(r_udp_ck, w_old_w, w_new_w);
        end
    end

    // Result formation
    assign w_xmit = (r_req.func == urhr_pkg::FUNC_PACKET) && o_sts.qualify && r_hit;

    always_comb begin
        if (r_req.udp_checksum == urhr_pkg::CK_NONE) begin
            w_udp_final = urhr_pkg::CK_NONE;
        end else if (r_udp_ck == urhr_pkg::CK_NONE) begin
            w_udp_final = urhr_pkg::CK_ALL_ONES;
        end else begin
            w_udp_final = r_udp_ck;
        end
    end

    always_comb begin
        n_rsp = '0;
        if (r_req.func == urhr_pkg::FUNC_RULE) begin
            n_rsp.action = (r_hit || r_free_found) ? urhr_pkg::ACT_STORED
                                                   : urhr_pkg::ACT_FULL;
        end else if (w_xmit) begin
            n_rsp.action           = urhr_pkg::ACT_XMIT;
            n_rsp.out_dest_mac     = r_req.source_mac;
            n_rsp.out_source_mac   = r_req.dest_mac;
            n_rsp.out_dst_ip       = r_hit_tgt[47:16];
            n_rsp.out_udp_dport    = r_hit_tgt[15:0];
            n_rsp.out_ip_checksum  = r_ip_ck;
            n_rsp.out_udp_checksum = w_udp_final;
        end else begin
            n_rsp.action           = urhr_pkg::ACT_PASS;
            n_rsp.out_dest_mac     = r_req.dest_mac;
            n_rsp.out_source_mac   = r_req.source_mac;
            n_rsp.out_dst_ip       = r_req.dst_ip;
            n_rsp.out_udp_dport    = r_req.udp_dport;
            n_rsp.out_ip_checksum  = r_req.ip_checksum;
            n_rsp.out_udp_checksum = r_req.udp_checksum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_rsp      = r_rsp;

    // Status
    assign o_sts.func      = r_req.func;
    assign o_sts.qualify   = (r_req.frame_len >= urhr_pkg::MIN_FRAME_LEN) &&
                             (r_req.eth_type == urhr_pkg::ETHTYPE_IPV4) &&
                             (r_req.ip_protocol == urhr_pkg::PROTO_UDP);
    assign o_sts.scan_done = r_hit || (!w_idx_live && !r_rd_live);
    assign o_sts.hit       = r_hit;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

endmodule

@@ rtl/udp_relay_header_rewrite_top.sv @@
// ----------------------------------------------------------------------------
// udp_relay_header_rewrite_top
// Relay rule store and destination rewrite of parsed UDP/IPv4 headers, with
// incremental IP and UDP checksum update.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   tuser: func; tdata: parsed header / rule
//  m_*       out  m_tvalid/m_tready   tuser: action; tdata: rewritten fields
//
//  A packet that does not qualify skips the rule scan. Otherwise the rule scan
//  reads one store entry per cycle, and a match in slot k ends it early; a
//  matching packet then takes 3 checksum steps. Reset clears the rule valid
//  flops at once; no clearing pass.
//  A request is taken while a result waits; the next result stalls until taken.
// ----------------------------------------------------------------------------
module udp_relay_header_rewrite_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] frame_len, [31:16] eth_type, [39:32] ip_protocol,
    // [71:40] src_ip, [87:72] udp_sport, [119:88] dst_ip, [135:120] udp_dport,
    // [151:136] ip_checksum, [167:152] udp_checksum, [215:168] dest_mac,
    // [263:216] source_mac
    input  logic [263:0] s_tdata,
    // [0] func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] out_dest_mac, [95:48] out_source_mac, [127:96] out_dst_ip,
    // [143:128] out_udp_dport, [159:144] out_ip_checksum,
    // [175:160] out_udp_checksum
    output logic [175:0] m_tdata,
    // [1:0] action
    output logic [1:0]   m_tuser
);

    urhr_pkg::t_req w_req;
    urhr_pkg::t_rsp w_rsp;
    urhr_pkg::t_cmd w_cmd;
    urhr_pkg::t_sts w_sts;

    // Unpack request
    assign w_req.func         = s_tuser[0];
    assign w_req.frame_len    = s_tdata[15:0];
    assign w_req.eth_type     = s_tdata[31:16];
    assign w_req.ip_protocol  = s_tdata[39:32];
    assign w_req.src_ip       = s_tdata[71:40];
    assign w_req.udp_sport    = s_tdata[87:72];
    assign w_req.dst_ip       = s_tdata[119:88];
    assign w_req.udp_dport    = s_tdata[135:120];
    assign w_req.ip_checksum  = s_tdata[151:136];
    assign w_req.udp_checksum = s_tdata[167:152];
    assign w_req.dest_mac     = s_tdata[215:168];
    assign w_req.source_mac   = s_tdata[263:216];

    urhr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    urhr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (w_req),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_rsp      (w_rsp)
    );

    // Pack result
    assign m_tuser = w_rsp.action;
    assign m_tdata = {w_rsp.out_udp_checksum, w_rsp.out_ip_checksum,
                      w_rsp.out_udp_dport, w_rsp.out_dst_ip,
                      w_rsp.out_source_mac, w_rsp.out_dest_mac};

    // Result register is loaded only when it is free
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    // One request in flight: no request taken right after one was taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // Rule store written only for a rule write
    a_store_rule_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store |-> (w_sts.func == urhr_pkg::FUNC_RULE))
        else $error("rule store written for a packet request");

    // Checksum steps only for a matching, qualifying packet
    a_ck_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ck_step |-> (w_sts.hit && w_sts.qualify &&
                           w_sts.func == urhr_pkg::FUNC_PACKET))
        else $error("checksum update without a rule match");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the UDP relay header rewrite block. A rule table and checksum
// predictor track each accepted request; every result is compared field by
// field in order. A short directed table comes first: rule writes, an
// overwrite, every pass-up reason, a zero UDP checksum and a computed-zero
// UDP checksum. Random rule writes and packets follow, drawn mostly from a
// key pool so that the table fills up and matches are frequent. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    typedef urhr_pkg::t_req    t_req;
    typedef urhr_pkg::t_rsp    t_rsp;
    typedef urhr_pkg::t_action t_action;

    localparam int          RULE_SLOTS    = urhr_pkg::RULE_SLOTS;
    localparam logic        FUNC_RULE     = urhr_pkg::FUNC_RULE;
    localparam logic        FUNC_PACKET   = urhr_pkg::FUNC_PACKET;
    localparam t_action     ACT_PASS      = urhr_pkg::ACT_PASS;
    localparam t_action     ACT_XMIT      = urhr_pkg::ACT_XMIT;
    localparam t_action     ACT_STORED    = urhr_pkg::ACT_STORED;
    localparam t_action     ACT_FULL      = urhr_pkg::ACT_FULL;
    localparam logic [15:0] MIN_FRAME_LEN = urhr_pkg::MIN_FRAME_LEN;
    localparam logic [15:0] ETHTYPE_IPV4  = urhr_pkg::ETHTYPE_IPV4;
    localparam logic [7:0]  PROTO_UDP     = urhr_pkg::PROTO_UDP;
    localparam logic [15:0] CK_NONE       = urhr_pkg::CK_NONE;
    localparam logic [15:0] CK_ALL_ONES   = urhr_pkg::CK_ALL_ONES;

    localparam int DIR_ROWS   = 16;
    localparam int RAND_ITEMS = 1584;
    localparam int KEY_POOL   = 80;
    localparam int IDLE_PCT   = 38;

    // relay target that the directed overwrite leaves on the main key
    localparam logic [31:0] RELAY_IP   = 32'h0A00_0007;
    localparam logic [15:0] RELAY_PORT = 16'h2328;

    typedef struct {
        t_req    hdr;
        bit      typed;      // expected result typed in below
        t_action act;
        bit      hunt_zero;  // pick a UDP checksum whose update comes out zero
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [263:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic [1:0]   m_tuser;

    // predictor state
    bit          rule_valid  [RULE_SLOTS];
    logic [47:0] rule_key    [RULE_SLOTS];
    logic [47:0] rule_target [RULE_SLOTS];

    t_rsp pending_rsp[$];
    int   mismatches   = 0;
    int   items_sent   = 0;
    int   results_seen = 0;
    int   hold_left    = 0;
    bit   held         = 1'b0;

    udp_relay_header_rewrite_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // one's-complement word swap: ~(~hc + ~old + new), end-around carry
    function automatic logic [15:0] ones_swap(input logic [15:0] hc,
                                              input logic [15:0] old_w,
                                              input logic [15:0] new_w);
        logic [31:0] s;
        s = {16'h0, ~hc} + {16'h0, ~old_w} + {16'h0, new_w};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return ~s[15:0];
    endfunction

    // UDP checksum update over both IP words and the port, before the zero fixup
    function automatic logic [15:0] udp_update(input logic [15:0] hc,
                                               input logic [31:0] old_ip,
                                               input logic [15:0] old_port,
                                               input logic [31:0] new_ip,
                                               input logic [15:0] new_port);
        logic [15:0] c;
        c = ones_swap(hc, old_ip[31:16], new_ip[31:16]);
        c = ones_swap(c, old_ip[15:0], new_ip[15:0]);
        return ones_swap(c, old_port, new_port);
    endfunction

    // rule table update or header rewrite for one accepted request
    function automatic t_rsp predict_rewrite(input t_req r);
        t_rsp        rsp;
        logic [47:0] key;
        logic [31:0] nip;
        logic [15:0] nport;
        logic [15:0] c;
        int          slot;
        rsp  = '0;
        key  = {r.src_ip, r.udp_sport};
        slot = -1;
        for (int i = 0; i < RULE_SLOTS; i++)
            if (slot < 0 && rule_valid[i] && rule_key[i] == key) slot = i;

        if (r.func == FUNC_RULE) begin
            for (int i = 0; i < RULE_SLOTS; i++)
                if (slot < 0 && !rule_valid[i]) slot = i;
            if (slot < 0) begin
                rsp.action = ACT_FULL;
            end else begin
                rule_valid[slot]  = 1'b1;
                rule_key[slot]    = key;
                rule_target[slot] = {r.dst_ip, r.udp_dport};
                rsp.action        = ACT_STORED;
            end
            return rsp;
        end

        rsp = '{ACT_PASS, r.dest_mac, r.source_mac, r.dst_ip, r.udp_dport,
                r.ip_checksum, r.udp_checksum};
        if (r.frame_len < MIN_FRAME_LEN || r.eth_type != ETHTYPE_IPV4 ||
            r.ip_protocol != PROTO_UDP || slot < 0)
            return rsp;

        nip   = rule_target[slot][47:16];
        nport = rule_target[slot][15:0];
        c = ones_swap(r.ip_checksum, r.dst_ip[31:16], nip[31:16]);
        rsp.out_ip_checksum = ones_swap(c, r.dst_ip[15:0], nip[15:0]);
        if (r.udp_checksum != CK_NONE) begin
            c = udp_update(r.udp_checksum, r.dst_ip, r.udp_dport, nip, nport);
            rsp.out_udp_checksum = (c == CK_NONE) ? CK_ALL_ONES : c;
        end
        rsp.action         = ACT_XMIT;
        rsp.out_dest_mac   = r.source_mac;
        rsp.out_source_mac = r.dest_mac;
        rsp.out_dst_ip     = nip;
        rsp.out_udp_dport  = nport;
        return rsp;
    endfunction

    // offer one request, wait for the handshake, record what it should produce
    task automatic offer(input t_req r, input bit typed, input t_action act);
        t_rsp want;
        while (!(items_sent >= 900 && items_sent < 1150) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {r.source_mac, r.dest_mac, r.udp_checksum, r.ip_checksum,
                     r.udp_dport, r.dst_ip, r.udp_sport, r.src_ip, r.ip_protocol,
                     r.eth_type, r.frame_len};
        do @(posedge i_clk); while (!s_tready);
        want = predict_rewrite(r);
        if (typed) want = '{act, 48'h0, 48'h0, 32'h0, 16'h0, 16'h0, 16'h0};
        pending_rsp.push_back(want);
        items_sent++;
    endtask

    task automatic cmp_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // result side: check each accepted result, drive m_tready
    initial begin : result_check
        t_rsp want;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_rsp.pop_front();
                    cmp_field("action", 48'(want.action), 48'(m_tuser));
                    cmp_field("out_dest_mac", want.out_dest_mac, m_tdata[47:0]);
                    cmp_field("out_source_mac", want.out_source_mac, m_tdata[95:48]);
                    cmp_field("out_dst_ip", 48'(want.out_dst_ip),
                              48'(m_tdata[127:96]));
                    cmp_field("out_udp_dport", 48'(want.out_udp_dport),
                              48'(m_tdata[143:128]));
                    cmp_field("out_ip_checksum", 48'(want.out_ip_checksum),
                              48'(m_tdata[159:144]));
                    cmp_field("out_udp_checksum", 48'(want.out_udp_checksum),
                              48'(m_tdata[175:160]));
                end
            end
            // one long hold-off so the block backs up into its input
            if (!held && results_seen >= 400) begin
                held      = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (results_seen >= 850 && results_seen < 1150) ||
                            ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        t_dir_row    dir_tab [DIR_ROWS];
        logic [47:0] key_pool[KEY_POOL];
        logic [47:0] key;
        t_req        r;
        bit          found;
        int          h;

        // main key C0A8_0001:1234; zero key and all-ones key at the extremes
        dir_tab = '{
            '{'{FUNC_PACKET, 16'd60, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'h1C46, 16'h5A3B, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_RULE, 16'hFFFF, 16'hFFFF, 8'hFF, 32'h0, 16'h0,
                32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
                48'hFFFF_FFFF_FFFF}, 1'b1, ACT_STORED, 1'b0},
            '{'{FUNC_RULE, 16'h0, 16'h0, 8'h0, 32'hFFFF_FFFF, 16'hFFFF,
                32'h0, 16'h0, 16'h0, 16'h0, 48'h0, 48'h0}, 1'b1, ACT_STORED, 1'b0},
            '{'{FUNC_RULE, 16'd60, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0005, 16'h1F90, 16'h0, 16'h0, 48'h0, 48'h0},
                1'b1, ACT_STORED, 1'b0},
            // same key again: target overwritten in place
            '{'{FUNC_RULE, 16'd60, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                RELAY_IP, RELAY_PORT, 16'h1234, 16'h5678, 48'h0, 48'h0},
                1'b1, ACT_STORED, 1'b0},
            // shortest qualifying frame, no UDP checksum
            '{'{FUNC_PACKET, 16'd42, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'hB1E6, 16'h0, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'd41, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'hB1E6, 16'h7777, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'hFFFF, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'hB1E6, 16'hBEEF, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'd100, 16'h86DD, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'hB1E6, 16'hBEEF, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'd100, ETHTYPE_IPV4, 8'd6, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'hB1E6, 16'hBEEF, 48'h0011_2233_4455,
                48'h6677_8899_AABB}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'd1500, ETHTYPE_IPV4, PROTO_UDP, 32'h0, 16'h0,
                32'h0, 16'h0, 16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'h0},
                1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'd1500, ETHTYPE_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF,
                32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0001, 48'h0,
                48'hFFFF_FFFF_FFFF}, 1'b0, ACT_PASS, 1'b0},
            // update that lands on zero goes out as all ones
            '{'{FUNC_PACKET, 16'd64, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1234,
                32'h0A00_0001, 16'h0035, 16'h4321, 16'h0, 48'hA0A1_A2A3_A4A5,
                48'hB0B1_B2B3_B4B5}, 1'b0, ACT_PASS, 1'b1},
            // port off by one: no match
            '{'{FUNC_PACKET, 16'd64, ETHTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 16'h1235,
                32'h0A00_0001, 16'h0035, 16'h4321, 16'h1111, 48'hA0A1_A2A3_A4A5,
                48'hB0B1_B2B3_B4B5}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'h0, 16'h0, 8'h0, 32'h0, 16'h0,
                32'h1, 16'h1, 16'h1, 16'h1, 48'h1, 48'h2}, 1'b0, ACT_PASS, 1'b0},
            '{'{FUNC_PACKET, 16'hFFFF, 16'hFFFF, 8'hFF, 32'h0, 16'h0,
                32'h1, 16'h1, 16'h1, 16'h1, 48'h1, 48'h2}, 1'b0, ACT_PASS, 1'b0}
        };

        key_pool[0] = 48'h0;
        key_pool[1] = 48'hFFFF_FFFF_FFFF;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = 48'({$urandom, $urandom});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int n = 0; n < DIR_ROWS; n++) begin
            r = dir_tab[n].hdr;
            if (dir_tab[n].hunt_zero) begin
                found = 1'b0;
                for (h = 1; h < 65536 && !found; h++)
                    if (udp_update(16'(h), r.dst_ip, r.udp_dport, RELAY_IP,
                                   RELAY_PORT) == CK_NONE) begin
                        found = 1'b1;
                        r.udp_checksum = 16'(h);
                    end
            end
            offer(r, dir_tab[n].typed, dir_tab[n].act);
        end

        // random rule writes and packets, mostly on pooled keys
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r.func = ($urandom_range(0, 99) < 30) ? FUNC_RULE : FUNC_PACKET;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                : 48'({$urandom, $urandom});
            {r.src_ip, r.udp_sport} = key;
            if ($urandom_range(0, 99) < 85) begin
                r.frame_len   = 16'($urandom_range(42, 65535));
                r.eth_type    = ETHTYPE_IPV4;
                r.ip_protocol = PROTO_UDP;
            end else begin
                r.frame_len   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 41))
                                                            : 16'($urandom);
                r.eth_type    = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                            : ETHTYPE_IPV4;
                r.ip_protocol = ($urandom_range(0, 1) == 0) ? 8'($urandom) : PROTO_UDP;
            end
            r.dst_ip       = $urandom;
            r.udp_dport    = 16'($urandom);
            r.ip_checksum  = 16'($urandom);
            r.udp_checksum = ($urandom_range(0, 99) < 10) ? CK_NONE : 16'($urandom);
            r.dest_mac     = 48'({$urandom, $urandom});
            r.source_mac   = 48'({$urandom, $urandom});
            offer(r, 1'b0, ACT_PASS);
        end
        s_tvalid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ udp_relay_header_rewrite_top.f @@
rtl/urhr_pkg.sv
rtl/urhr_ctrl.sv
rtl/urhr_dp.sv
rtl/udp_relay_header_rewrite_top.sv
tb/testbench.sv
